// File: rtl/core/esft_pkg.sv
`timescale 1ns / 1ps
// esft_pkg: shared types and constants of the engine speed block
// no dependencies
package esft_pkg;

	localparam int unsigned NUM_W     = 22;
	localparam logic [NUM_W-1:0] SPEED_NUM = 22'd3840000;
	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_SPEED_LOW        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_SPEED_TARGET     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_IDLE_AVERAGE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD_HIGH_IDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD_HIGH      = 3'd4;

	localparam logic [13:0] IDLE_SPEED_LOW_RST        = 14'd64;
	localparam logic [13:0] IDLE_SPEED_TARGET_RST     = 14'd64;
	localparam logic [7:0]  MAX_IDLE_AVERAGE_RST      = 8'd110;
	localparam logic [7:0]  SLOW_PERIOD_HIGH_IDLE_RST = 8'd8;
	localparam logic [7:0]  SLOW_PERIOD_HIGH_RST      = 8'd9;

	localparam logic [7:0] DEV_SEED = 8'h20;

	localparam int unsigned IN_W  = 24;
	localparam int unsigned OUT_W = 112;

	typedef struct packed {
		logic [3:0]  pad;
		logic        mark_restart;
		logic        mark_break;
		logic        idle_feedback;
		logic        engine_starting;
		logic [15:0] period;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  pad;
		logic [7:0]  deviation_sum;
		logic [6:0]  long_average;
		logic [6:0]  short_average;
		logic [15:0] min_period;
		logic [7:0]  trend_bits;
		logic [6:0]  status_flags;
		logic [7:0]  speed_degree;
		logic [4:0]  speed_mode;
		logic [3:0]  speed_order;
		logic [7:0]  speed_coarse;
		logic [13:0] speed_mid;
		logic [15:0] speed_fine;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic update;
	} esft_cmd_t;

	typedef struct packed {
		logic div_done;
	} esft_status_t;

endpackage

// File: rtl/core/esft_div.sv
`timescale 1ns / 1ps
// esft_div: serial restoring divider, constant numerator over a 16-bit divisor
// depends on esft_pkg
module esft_div
	import esft_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [15:0]      divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	logic [15:0]      rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, numerator shifts out of the top of quo_q
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= SPEED_NUM;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = !busy_q;

endmodule

// File: rtl/core/esft_dp.sv
`timescale 1ns / 1ps
// esft_dp: input capture, speed divider, derived speeds, flags, averages
// depends on esft_pkg and esft_div
module esft_dp
	import esft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_W-1:0]       s_tdata,
	output logic [OUT_W-1:0]      m_tdata,
	input  esft_cmd_t             cmd,
	output esft_status_t          status
);

	// configuration
	logic [13:0] idle_low_q;
	logic [13:0] idle_target_q;
	logic [7:0]  max_avg_q;
	logic [7:0]  slow_hi_idle_q;
	logic [7:0]  slow_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_low_q     <= IDLE_SPEED_LOW_RST;
			idle_target_q  <= IDLE_SPEED_TARGET_RST;
			max_avg_q      <= MAX_IDLE_AVERAGE_RST;
			slow_hi_idle_q <= SLOW_PERIOD_HIGH_IDLE_RST;
			slow_hi_q      <= SLOW_PERIOD_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IDLE_SPEED_LOW:        idle_low_q     <= cfg_data;
				REG_IDLE_SPEED_TARGET:     idle_target_q  <= cfg_data;
				REG_MAX_IDLE_AVERAGE:      max_avg_q      <= cfg_data[7:0];
				REG_SLOW_PERIOD_HIGH_IDLE: slow_hi_idle_q <= cfg_data[7:0];
				REG_SLOW_PERIOD_HIGH:      slow_hi_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// captured input word
	in_word_t in_q;

	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= in_word_t'(s_tdata);
	end

	logic [NUM_W-1:0] quo;

	esft_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.divisor  (in_q.period),
		.quotient (quo),
		.done     (status.div_done)
	);

	// running state
	logic [15:0] last_period_q;
	logic [7:0]  trend_q;
	logic [7:0]  spd_low_q;
	logic [7:0]  hist1_q;
	logic [7:0]  hist2_q;
	logic        reached_q;
	logic [10:0] short_sum_q;
	logic [6:0]  short_avg_q;
	logic [12:0] long_sum_q;
	logic [6:0]  long_avg_q;
	logic [7:0]  dev_q;
	logic [7:0]  below_q;

	logic [15:0] fine;
	logic [13:0] mid;
	logic [7:0]  coarse;
	logic [3:0]  order;
	logic [4:0]  mode;
	logic [4:0]  band;
	logic [7:0]  trend_n;
	logic [15:0] lp_n;
	logic [15:0] minp;
	logic        low_flag;
	logic        decel;
	logic        above10;
	logic        above30;
	logic        reached_n;
	logic [6:0]  flags;
	logic [6:0]  clip;
	logic [10:0] ss_run;
	logic [12:0] ls_run;
	logic [6:0]  sa_run;
	logic [6:0]  la_run;
	logic        track;
	logic [7:0]  bc_base;
	logic [7:0]  bc_run;
	logic [7:0]  dev_leak;
	logic [6:0]  diff;
	logic [8:0]  dev_sum;
	logic [7:0]  dev_run;
	logic [10:0] ss_n;
	logic [12:0] ls_n;
	logic [6:0]  sa_n;
	logic [6:0]  la_n;
	logic [7:0]  dev_n;
	logic [7:0]  below_n;

	always_comb begin
		// speed from the divider, saturated on zero or tiny period
		fine   = (in_q.period == 16'd0 || quo[NUM_W-1:16] != '0) ? 16'hffff : quo[15:0];
		mid    = fine[15:2];
		coarse = (mid[13:10] != 4'd0) ? 8'hff : mid[9:2];

		trend_n  = {trend_q[6:0], in_q.period < last_period_q};
		lp_n     = (in_q.mark_break && in_q.mark_restart) ? last_period_q : in_q.period;
		minp     = lp_n - {2'b00, lp_n[15:2]};
		low_flag = in_q.idle_feedback ? (in_q.period[15:8] >= slow_hi_idle_q)
		                              : (in_q.period[15:8] >= slow_hi_q);

		decel     = (hist1_q >= spd_low_q) && (spd_low_q > mid[7:0]);
		above10   = {1'b0, mid} > ({1'b0, idle_low_q} + 15'd10);
		above30   = {1'b0, mid} > ({1'b0, idle_low_q} + 15'd30);
		reached_n = (mid <= idle_target_q) ? 1'b1 : (above30 ? 1'b0 : reached_q);

		// band is (coarse-24)/8; mode is (mid-96)&31 which is just mid[4:0]
		band = 5'((coarse - 8'd24) >> 3);
		if (coarse < 8'd24) begin
			order = 4'd0;
			mode  = 5'd0;
		end else if (band > 5'd15) begin
			order = 4'd15;
			mode  = 5'h1f;
		end else begin
			order = band[3:0];
			mode  = mid[4:0];
		end

		flags = {low_flag, mid > 14'd128, reached_n, above30, above10, decel, order == 4'd15};

		clip   = (mid >= 14'd128) ? 7'd127 : mid[6:0];
		ss_run = short_sum_q - {4'd0, short_avg_q} + {4'd0, clip};
		ls_run = long_sum_q - {6'd0, long_avg_q} + {6'd0, clip};
		sa_run = ss_run[10:4];
		la_run = ls_run[12:6];
		track  = ({1'b0, sa_run} < max_avg_q)
		      && ({2'b00, clip} < ({1'b0, max_avg_q} + 9'd5));

		bc_base  = (sa_run < clip) ? 8'd0 : below_q;
		bc_run   = (bc_base == 8'hff) ? 8'hff : bc_base + 8'd1;
		dev_leak = dev_q - {4'd0, dev_q[7:4]};
		diff     = (sa_run >= clip) ? sa_run - clip : clip - sa_run;
		dev_sum  = {1'b0, dev_leak} + {2'b00, diff};
		dev_run  = dev_sum[8] ? 8'hff : dev_sum[7:0];

		if (in_q.engine_starting) begin
			ss_n    = {clip, 4'd0};
			ls_n    = {clip, 6'd0};
			sa_n    = clip;
			la_n    = clip;
			dev_n   = DEV_SEED;
			below_n = below_q;
		end else begin
			ss_n    = ss_run;
			ls_n    = ls_run;
			sa_n    = sa_run;
			la_n    = la_run;
			below_n = track ? bc_run : below_q;
			dev_n   = (track && bc_run < 8'd16) ? dev_run : dev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_period_q <= '0;
			trend_q       <= '0;
			spd_low_q     <= '0;
			hist1_q       <= '0;
			hist2_q       <= '0;
			reached_q     <= 1'b0;
			short_sum_q   <= '0;
			short_avg_q   <= '0;
			long_sum_q    <= '0;
			long_avg_q    <= '0;
			dev_q         <= '0;
			below_q       <= '0;
		end else if (cmd.update) begin
			last_period_q <= lp_n;
			trend_q       <= trend_n;
			spd_low_q     <= mid[7:0];
			hist1_q       <= spd_low_q;
			hist2_q       <= hist1_q;
			reached_q     <= reached_n;
			short_sum_q   <= ss_n;
			short_avg_q   <= sa_n;
			long_sum_q    <= ls_n;
			long_avg_q    <= la_n;
			dev_q         <= dev_n;
			below_q       <= below_n;
		end
	end

	// output word register
	out_word_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q.pad           <= '0;
			out_q.deviation_sum <= dev_n;
			out_q.long_average  <= la_n;
			out_q.short_average <= sa_n;
			out_q.min_period    <= minp;
			out_q.trend_bits    <= trend_n;
			out_q.status_flags  <= flags;
			out_q.speed_degree  <= {order, mode[4:1]};
			out_q.speed_mode    <= mode;
			out_q.speed_order   <= order;
			out_q.speed_coarse  <= coarse;
			out_q.speed_mid     <= mid;
			out_q.speed_fine    <= fine;
		end
	end

	assign m_tdata = out_q;

endmodule

// File: rtl/core/esft_ctrl.sv
`timescale 1ns / 1ps
// esft_ctrl: item sequencer and output word valid
// depends on esft_pkg
module esft_ctrl
	import esft_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  esft_status_t status,
	output esft_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free   = !m_tvalid_q || m_tready;
	assign s_tready   = state_q == ST_IDLE;
	assign cmd.load   = s_tready && s_tvalid;
	assign cmd.update = (state_q == ST_UPD) && out_free;
	assign m_tvalid   = m_tvalid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.load) state_n = ST_DIV;
			ST_DIV:  if (status.div_done) state_n = ST_UPD;
			ST_UPD:  if (cmd.update) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.update)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// divider must be running right after a word is taken
	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DIV) && !status.div_done)
		else $error("divider not busy after load");

	// results only computed once the divider has finished
	a_update_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> status.div_done)
		else $error("update while divider busy");

	// an update always presents a word on the output
	a_update_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> m_tvalid)
		else $error("output word missing after update");

	// no new word is taken while one is in flight
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready while busy");

endmodule

// File: rtl/core/engine_speed_from_tooth_period.sv
`timescale 1ns / 1ps
// engine_speed_from_tooth_period: speed, bands, flags and averages per crank period
// Flow: an accepted input word starts the 22-step serial divider (one quotient
// bit a cycle); once it is done, the update state registers the output word,
// waiting while the previous output word waits on m_tready, and the block then
// returns to idle. It takes no new input word until it is back in idle.
// Reset: arst_n asynchronous, clears all running state, config to defaults.
module engine_speed_from_tooth_period
	import esft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// period[15:0], engine_starting[16], idle_feedback[17], mark_break[18],
	// mark_restart[19], zero[23:20]
	input  logic [IN_W-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// speed_fine[15:0], speed_mid[29:16], speed_coarse[37:30], speed_order[41:38],
	// speed_mode[46:42], speed_degree[54:47], status_flags[61:55],
	// trend_bits[69:62], min_period[85:70], short_average[92:86],
	// long_average[99:93], deviation_sum[107:100], zero[111:108]
	output logic [OUT_W-1:0]      m_tdata
);

	esft_cmd_t    cmd;
	esft_status_t status;

	esft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	esft_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// File: bench/engine_speed_from_tooth_period_test.sv
`timescale 1ns / 1ps
// engine_speed_from_tooth_period_test: self-checking bench for the crank-period speed block
// streams period words under random gaps and back-pressure, predicts and checks each result word
// depends on esft_pkg and engine_speed_from_tooth_period
module engine_speed_from_tooth_period_test;
	import esft_pkg::*;

	localparam int unsigned RESET_CYCLES  = 8;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned HOLD_AFTER    = 300;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_WORDS   = 310;
	localparam int unsigned NUM_PHASES    = 6;
	localparam int unsigned MAX_PRINTED   = 64;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {RUN_IDLE, RUN_CRUISE, RUN_FAST, RUN_NOISE} run_kind_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;

	// predictor copy of the registers
	logic [13:0] idle_low_q    = IDLE_SPEED_LOW_RST;
	logic [13:0] idle_target_q = IDLE_SPEED_TARGET_RST;
	logic [7:0]  max_avg_q     = MAX_IDLE_AVERAGE_RST;
	logic [7:0]  slow_idle_q   = SLOW_PERIOD_HIGH_IDLE_RST;
	logic [7:0]  slow_q        = SLOW_PERIOD_HIGH_RST;

	// predictor copy of the running state
	logic [15:0] last_period_q = '0;
	logic [7:0]  trend_q       = '0;
	logic [7:0]  speed_low_q   = '0;
	logic [7:0]  speed_hist1_q = '0;
	logic [7:0]  speed_hist2_q = '0;
	logic        reached_q     = 1'b0;
	logic [10:0] short_sum_q   = '0;
	logic [6:0]  short_avg_q   = '0;
	logic [12:0] long_sum_q    = '0;
	logic [6:0]  long_avg_q    = '0;
	logic [7:0]  deviation_q   = '0;
	logic [7:0]  below_q       = '0;

	in_word_t    words_to_send[$];
	out_word_t   speed_words_due[$];
	out_word_t   seen_word;
	out_word_t   due_word;
	int unsigned send_idle_pct = 32;
	int unsigned recv_idle_pct = 71;
	int unsigned mismatches    = 0;
	int unsigned stall_cycles  = 0;
	int unsigned results_seen  = 0;
	int unsigned hold_left     = 0;
	bit          hold_done     = 1'b0;

	engine_speed_from_tooth_period u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// speed, bands, flags and averages for one period word; advances the state copy
	function automatic out_word_t predict_speed(in_word_t w);
		out_word_t   r;
		int unsigned fine, mid, coarse, order, mode, clip, diff, sum;
		r = '0;
		trend_q = {trend_q[6:0], w.period < last_period_q};
		if (!(w.mark_break && w.mark_restart)) begin
			last_period_q = w.period;
		end
		r.min_period = last_period_q - (last_period_q >> 2);
		if (w.idle_feedback ? (w.period[15:8] >= slow_idle_q) : (w.period[15:8] >= slow_q)) begin
			r.status_flags[6] = 1'b1;
		end

		if (w.period == 0) begin
			fine = 'hffff;
		end else begin
			fine = SPEED_NUM / w.period;
			if (fine > 'hffff) fine = 'hffff;
		end
		mid = fine >> 2;
		coarse = mid >> 2;
		if (coarse > 255) coarse = 255;

		// falling low byte over the last three speeds
		speed_hist2_q = speed_hist1_q;
		speed_hist1_q = speed_low_q;
		speed_low_q = mid[7:0];
		if (speed_hist2_q >= speed_hist1_q && speed_hist1_q > speed_low_q) begin
			r.status_flags[1] = 1'b1;
		end
		if (mid > idle_low_q + 10) r.status_flags[2] = 1'b1;
		if (mid > idle_low_q + 30) begin
			reached_q = 1'b0;
			r.status_flags[3] = 1'b1;
		end
		if (mid <= idle_target_q) reached_q = 1'b1;
		r.status_flags[4] = reached_q;
		if (mid > 128) r.status_flags[5] = 1'b1;

		if (coarse >= 24) begin
			order = (coarse - 24) / 8;
			mode = (mid - 96) & 'h1f;
			if (order > 15) begin
				order = 15;
				mode = 'h1f;
			end
		end else begin
			order = 0;
			mode = 0;
		end
		if (order == 15) r.status_flags[0] = 1'b1;

		clip = (mid >= 128) ? 127 : mid;
		if (w.engine_starting) begin
			short_avg_q = 7'(clip);
			short_sum_q = 11'(clip << 4);
			deviation_q = DEV_SEED;
			long_avg_q = 7'(clip);
			long_sum_q = 13'(clip << 6);
		end else begin
			short_sum_q = 11'(short_sum_q - short_avg_q + clip);
			long_sum_q = 13'(long_sum_q - long_avg_q + clip);
			long_avg_q = long_sum_q[12:6];
			short_avg_q = short_sum_q[10:4];
			if (short_avg_q < max_avg_q && clip < max_avg_q + 5) begin
				if (short_avg_q < clip) below_q = '0;
				if (below_q < 255) below_q = below_q + 8'd1;
				if (below_q < 16) begin
					deviation_q = deviation_q - (deviation_q >> 4);
					diff = (short_avg_q >= clip) ? short_avg_q - clip : clip - short_avg_q;
					sum = deviation_q + diff;
					deviation_q = 8'((sum > 255) ? 255 : sum);
				end
			end
		end

		r.speed_fine    = 16'(fine);
		r.speed_mid     = 14'(mid);
		r.speed_coarse  = 8'(coarse);
		r.speed_order   = 4'(order);
		r.speed_mode    = 5'(mode);
		r.speed_degree  = {order[3:0], mode[4:1]};
		r.trend_bits    = trend_q;
		r.short_average = short_avg_q;
		r.long_average  = long_avg_q;
		r.deviation_sum = deviation_q;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatches < MAX_PRINTED) begin
			$display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	task automatic queue_word(int unsigned period, bit starting, bit idle_fb, bit brk, bit restart);
		in_word_t w;
		w = '0;
		w.period = 16'(period);
		w.engine_starting = starting;
		w.idle_feedback = idle_fb;
		w.mark_break = brk;
		w.mark_restart = restart;
		words_to_send.push_back(w);
	endtask

	// one register write per clock; the predictor copy follows at once since the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_IDLE_SPEED_LOW:        idle_low_q = data[13:0];
			REG_IDLE_SPEED_TARGET:     idle_target_q = data[13:0];
			REG_MAX_IDLE_AVERAGE:      max_avg_q = data[7:0];
			REG_SLOW_PERIOD_HIGH_IDLE: slow_idle_q = data[7:0];
			REG_SLOW_PERIOD_HIGH:      slow_q = data[7:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_all();
		while (words_to_send.size() != 0 || s_tvalid || speed_words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: holds a word until taken, then maybe idles before the next
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			speed_words_due.push_back(predict_speed(in_word_t'(s_tdata)));
		end
		if (!s_tvalid || s_tready) begin
			if (arst_n && words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= words_to_send.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: checks each result word, random stalls and one long hold-off
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen_word = out_word_t'(m_tdata);
			results_seen++;
			if (speed_words_due.size() == 0) begin
				report_mismatch("word with no prediction, speed_fine", seen_word.speed_fine, 0);
			end else begin
				due_word = speed_words_due.pop_front();
				if (seen_word.speed_fine != due_word.speed_fine)
					report_mismatch("speed_fine", seen_word.speed_fine, due_word.speed_fine);
				if (seen_word.speed_mid != due_word.speed_mid)
					report_mismatch("speed_mid", seen_word.speed_mid, due_word.speed_mid);
				if (seen_word.speed_coarse != due_word.speed_coarse)
					report_mismatch("speed_coarse", seen_word.speed_coarse, due_word.speed_coarse);
				if (seen_word.speed_order != due_word.speed_order)
					report_mismatch("speed_order", seen_word.speed_order, due_word.speed_order);
				if (seen_word.speed_mode != due_word.speed_mode)
					report_mismatch("speed_mode", seen_word.speed_mode, due_word.speed_mode);
				if (seen_word.speed_degree != due_word.speed_degree)
					report_mismatch("speed_degree", seen_word.speed_degree, due_word.speed_degree);
				if (seen_word.status_flags != due_word.status_flags)
					report_mismatch("status_flags", seen_word.status_flags, due_word.status_flags);
				if (seen_word.trend_bits != due_word.trend_bits)
					report_mismatch("trend_bits", seen_word.trend_bits, due_word.trend_bits);
				if (seen_word.min_period != due_word.min_period)
					report_mismatch("min_period", seen_word.min_period, due_word.min_period);
				if (seen_word.short_average != due_word.short_average)
					report_mismatch("short_average", seen_word.short_average,
						due_word.short_average);
				if (seen_word.long_average != due_word.long_average)
					report_mismatch("long_average", seen_word.long_average,
						due_word.long_average);
				if (seen_word.deviation_sum != due_word.deviation_sum)
					report_mismatch("deviation_sum", seen_word.deviation_sum,
						due_word.deviation_sum);
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && results_seen == HOLD_AFTER) begin
			// long back-pressure so the block fills and stalls its input
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("engine_speed_from_tooth_period_test: FAIL");
		$finish;
	end

	initial begin
		int unsigned queued;
		int          base, spread, step, p, len, crank_len, pick;
		run_kind_t   kind;
		bit          idle_fb, paused;
		paused = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset register values
		queue_word(15000, 1, 0, 0, 0);
		queue_word(0, 0, 0, 0, 0);      // divide by zero saturates
		queue_word(1, 0, 0, 0, 0);
		queue_word(58, 0, 0, 0, 0);     // last saturating period
		queue_word(59, 0, 0, 0, 0);
		queue_word(1666, 0, 0, 0, 0);   // top band
		queue_word(9846, 0, 0, 0, 0);   // first band edge
		queue_word(65535, 0, 1, 0, 0);
		queue_word(65535, 0, 0, 0, 0);
		queue_word(2048, 0, 0, 1, 1);   // break with restart keeps old period
		queue_word(3000, 0, 0, 1, 0);
		queue_word(3000, 0, 0, 0, 1);
		queue_word(2047, 0, 1, 0, 0);
		queue_word(2304, 0, 1, 0, 0);
		queue_word(14000, 0, 0, 0, 0);  // slowing down
		queue_word(15000, 0, 0, 0, 0);
		queue_word(16000, 0, 0, 0, 0);
		queue_word(17000, 0, 0, 0, 0);
		queue_word(15000, 0, 0, 0, 0);  // jitter around idle
		queue_word(14000, 0, 0, 0, 0);
		queue_word(16500, 0, 0, 0, 0);
		queue_word(15200, 0, 0, 0, 0);
		queue_word(14800, 0, 0, 0, 0);
		queue_word(0, 1, 0, 0, 0);      // start seed with clipped speed
		queue_word(60000, 0, 1, 0, 0);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_all();
			case (phase)
				0: begin
					write_reg(REG_IDLE_SPEED_LOW, '0);
					write_reg(REG_IDLE_SPEED_TARGET, '0);
					write_reg(REG_MAX_IDLE_AVERAGE, '0);
					write_reg(REG_SLOW_PERIOD_HIGH_IDLE, '0);
					write_reg(REG_SLOW_PERIOD_HIGH, '0);
				end
				1: begin
					// all ones also checks masking of the byte registers
					write_reg(REG_IDLE_SPEED_LOW, '1);
					write_reg(REG_IDLE_SPEED_TARGET, '1);
					write_reg(REG_MAX_IDLE_AVERAGE, '1);
					write_reg(REG_SLOW_PERIOD_HIGH_IDLE, '1);
					write_reg(REG_SLOW_PERIOD_HIGH, '1);
				end
				default: begin
					write_reg(REG_IDLE_SPEED_LOW, CFG_DATA_W'($urandom_range(120, 30)));
					write_reg(REG_IDLE_SPEED_TARGET, CFG_DATA_W'($urandom_range(130, 30)));
					write_reg(REG_MAX_IDLE_AVERAGE, CFG_DATA_W'($urandom_range(1) ?
						$urandom_range(140, 90) : $urandom_range(16383)));
					write_reg(REG_SLOW_PERIOD_HIGH_IDLE, CFG_DATA_W'($urandom_range(16383)));
					write_reg(REG_SLOW_PERIOD_HIGH, CFG_DATA_W'($urandom_range(16383)));
					write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(16383)));
				end
			endcase
			end_writes();

			if (phase < 2) begin
				send_idle_pct = 32;
				recv_idle_pct = 71;
			end else if (phase < 4) begin
				send_idle_pct = 71;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			queued = 0;
			while (queued < PHASE_WORDS) begin
				if (phase == 2 && !paused && queued >= PHASE_WORDS / 2) begin
					// sender pauses until every result is back
					drain_all();
					paused = 1'b1;
				end
				// a run of periods around one speed, drifting, or of random noise, maybe after cranking
				kind = run_kind_t'($urandom_range(3));
				case (kind)
					RUN_IDLE:   base = $urandom_range(40000, 8000);
					RUN_CRUISE: base = $urandom_range(8000, 1700);
					RUN_FAST:   base = $urandom_range(1700, 0);
					default:    base = $urandom_range(65535);
				endcase
				spread = base / 12 + 1;
				step = int'($urandom_range(spread / 2)) - spread / 4;
				len = $urandom_range(40, 6);
				crank_len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
				idle_fb = 1'($urandom_range(1));
				for (int i = 0; i < len; i++) begin
					if (kind == RUN_NOISE) begin
						p = $urandom_range(65535);
					end else begin
						p = base + step * i + int'($urandom_range(2 * spread)) - spread;
						if (p < 0) p = 0;
						if (p > 65535) p = 65535;
					end
					pick = $urandom_range(99);
					queue_word(p, i < crank_len || $urandom_range(49) == 0, idle_fb,
						pick < 8, pick < 3 || (pick >= 8 && pick < 13));
				end
				queued += len;
			end
		end

		drain_all();
		if (mismatches == 0) begin
			$display("engine_speed_from_tooth_period_test: PASS");
		end else begin
			$display("engine_speed_from_tooth_period_test: FAIL");
		end
		$finish;
	end

endmodule

// File: engine_speed_from_tooth_period.f
rtl/core/esft_pkg.sv
rtl/core/esft_div.sv
rtl/core/esft_dp.sv
rtl/core/esft_ctrl.sv
rtl/core/engine_speed_from_tooth_period.sv
bench/engine_speed_from_tooth_period_test.sv
